FILE: rtl/mau_pkg.sv
// shared constants and action codes for the modular arithmetic unit
`timescale 1ns / 1ps

package mau_pkg;

    localparam int OPERAND_BITS_DEF = 63;
    localparam int MODULUS_BITS_DEF = 31;
    localparam int ACTION_BITS      = 3;

    localparam logic [30:0] RESET_MODULUS = 31'd1000000007;

    localparam logic [ACTION_BITS-1:0] ACT_ADD = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_SUB = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_MUL = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_POW = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_INV = 3'd4;
    localparam logic [ACTION_BITS-1:0] ACT_DIV = 3'd5;

endpackage

FILE: rtl/modular_arithmetic_unit.sv
// modular arithmetic unit: add, subtract, multiply, power, inverse, divide mod a prime
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  input   | in        | i_in_valid / o_in_stall    | i_action, i_operand_a, i_operand_b
//  output  | out       | o_out_valid / i_out_stall  | o_residue
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data (modulus)
//
//  one item at a time; a bit-serial double-and-add unit does all reduction and multiplication.
//  operand a is reduced, then b; add/sub finish combinationally, multiply runs the serial unit,
//  power/inverse square-and-multiply from the top exponent bit, divide inverts b then multiplies.
//  synchronous active-low reset; modulus resets to 1000000007 (truncated to MODULUS_BITS bits).
//  the next item is taken while a finished result still waits under i_out_stall.
`timescale 1ns / 1ps

module modular_arithmetic_unit #(
    parameter int OPERAND_BITS = mau_pkg::OPERAND_BITS_DEF,
    parameter int MODULUS_BITS = mau_pkg::MODULUS_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [mau_pkg::ACTION_BITS-1:0]  i_action,
    input  logic [OPERAND_BITS-1:0]          i_operand_a,
    input  logic [OPERAND_BITS-1:0]          i_operand_b,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [MODULUS_BITS-1:0]          o_residue,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [MODULUS_BITS-1:0]          i_cfg_data
);
    import mau_pkg::*;

    localparam int OB = OPERAND_BITS;
    localparam int MB = MODULUS_BITS;
    localparam int EB = (OB > MB) ? OB : MB;
    localparam int CW = $clog2(EB);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_DISPATCH,
        S_MUL,
        S_POW_BIT,
        S_POW_SQ,
        S_POW_ML,
        S_POW_NXT,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [ACTION_BITS-1:0] r_act;
    logic [OB-1:0]          r_b;
    logic [MB-1:0]          r_mod;
    logic [MB-1:0]          r_ra;
    logic [MB-1:0]          r_rb;
    logic [MB-1:0]          r_mr;
    logic [MB-1:0]          r_mx;
    logic [EB-1:0]          r_sh;
    logic [CW-1:0]          r_cnt;
    logic [EB-1:0]          r_exp;
    logic [CW-1:0]          r_ecnt;
    logic [MB-1:0]          r_acc;
    logic [MB-1:0]          r_base;
    logic                   r_div;
    logic [MB-1:0]          r_res;
    logic                   r_out_valid;
    logic [MB-1:0]          r_residue;

    logic [MB:0]   m_ext;
    logic [MB:0]   dbl;
    logic [MB-1:0] dbl_red;
    logic [MB-1:0] addend;
    logic [MB:0]   step_sum;
    logic [MB-1:0] step_out;
    logic [MB:0]   add_sum;
    logic [MB-1:0] add_res;
    logic [MB:0]   sub_sum;
    logic [MB-1:0] sub_res;
    logic          out_free;

    // one double-and-add step: (2*r + bit*x) mod m
    always_comb begin
        m_ext    = {1'b0, r_mod};
        dbl      = {r_mr, 1'b0};
        dbl_red  = (dbl >= m_ext) ? MB'(dbl - m_ext) : dbl[MB-1:0];
        addend   = r_sh[EB-1] ? r_mx : '0;
        step_sum = {1'b0, dbl_red} + {1'b0, addend};
        step_out = (step_sum >= m_ext) ? MB'(step_sum - m_ext) : step_sum[MB-1:0];
        add_sum  = {1'b0, r_ra} + {1'b0, r_rb};
        add_res  = (add_sum >= m_ext) ? MB'(add_sum - m_ext) : add_sum[MB-1:0];
        sub_sum  = {1'b0, r_ra} + m_ext - {1'b0, r_rb};
        sub_res  = (sub_sum >= m_ext) ? MB'(sub_sum - m_ext) : sub_sum[MB-1:0];
    end

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_residue   = r_residue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mod       <= RESET_MODULUS[MB-1:0];
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mod <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // serial unit advances in the reduction, multiply, square and multiply-by-base states
            if (r_state == S_RED_A || r_state == S_RED_B || r_state == S_MUL ||
                r_state == S_POW_SQ || r_state == S_POW_ML) begin
                r_mr  <= step_out;
                r_sh  <= r_sh << 1;
                r_cnt <= r_cnt - CW'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act   <= i_action;
                        r_b     <= i_operand_b;
                        r_sh    <= EB'(i_operand_a);
                        r_mx    <= MB'(1);
                        r_mr    <= '0;
                        r_cnt   <= CW'(EB - 1);
                        r_state <= S_RED_A;
                    end
                end
                S_RED_A: begin
                    if (r_cnt == '0) begin
                        r_ra    <= step_out;
                        r_sh    <= EB'(r_b);
                        r_mr    <= '0;
                        r_cnt   <= CW'(EB - 1);
                        r_state <= S_RED_B;
                    end
                end
                S_RED_B: begin
                    if (r_cnt == '0) begin
                        r_rb    <= step_out;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_res   <= '0;
                    r_state <= S_DONE;
                    r_acc   <= MB'(1);
                    r_ecnt  <= CW'(EB - 1);
                    r_div   <= 1'b0;
                    if (r_mod >= MB'(2)) begin
                        unique case (r_act)
                            ACT_ADD: r_res <= add_res;
                            ACT_SUB: r_res <= sub_res;
                            ACT_MUL: begin
                                r_mx    <= r_ra;
                                r_sh    <= EB'(r_rb) << (EB - MB);
                                r_mr    <= '0;
                                r_cnt   <= CW'(MB - 1);
                                r_state <= S_MUL;
                            end
                            ACT_POW: begin
                                r_base  <= r_ra;
                                r_exp   <= EB'(r_b);
                                r_state <= S_POW_BIT;
                            end
                            ACT_INV: begin
                                if (r_ra != '0) begin
                                    r_base  <= r_ra;
                                    r_exp   <= EB'(r_mod - MB'(2));
                                    r_state <= S_POW_BIT;
                                end
                            end
                            ACT_DIV: begin
                                if (r_rb != '0) begin
                                    r_base  <= r_rb;
                                    r_exp   <= EB'(r_mod - MB'(2));
                                    r_div   <= 1'b1;
                                    r_state <= S_POW_BIT;
                                end
                            end
                            default: r_res <= '0;
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_cnt == '0) begin
                        r_res   <= step_out;
                        r_state <= S_DONE;
                    end
                end
                S_POW_BIT: begin
                    // square the accumulator
                    r_mx    <= r_acc;
                    r_sh    <= EB'(r_acc) << (EB - MB);
                    r_mr    <= '0;
                    r_cnt   <= CW'(MB - 1);
                    r_state <= S_POW_SQ;
                end
                S_POW_SQ: begin
                    if (r_cnt == '0) begin
                        r_acc <= step_out;
                        if (r_exp[EB-1]) begin
                            r_mx    <= step_out;
                            r_sh    <= EB'(r_base) << (EB - MB);
                            r_mr    <= '0;
                            r_cnt   <= CW'(MB - 1);
                            r_state <= S_POW_ML;
                        end else begin
                            r_state <= S_POW_NXT;
                        end
                    end
                end
                S_POW_ML: begin
                    if (r_cnt == '0) begin
                        r_acc   <= step_out;
                        r_state <= S_POW_NXT;
                    end
                end
                S_POW_NXT: begin
                    r_exp <= r_exp << 1;
                    if (r_ecnt == '0) begin
                        if (r_div) begin
                            r_mx    <= r_ra;
                            r_sh    <= EB'(r_acc) << (EB - MB);
                            r_mr    <= '0;
                            r_cnt   <= CW'(MB - 1);
                            r_state <= S_MUL;
                        end else begin
                            r_res   <= r_acc;
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_ecnt  <= r_ecnt - CW'(1);
                        r_state <= S_POW_BIT;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_residue   <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/mau_checker.sv
// port-level checks for the modular arithmetic unit, bound to the top level
`timescale 1ns / 1ps

module mau_checker #(
    parameter int MODULUS_BITS = mau_pkg::MODULUS_BITS_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [MODULUS_BITS-1:0] o_residue,
    input logic                    o_cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_residue))
        else $error("stalled result changed");

    // an accepted transaction keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block not busy after accepting a transaction");

    // a result appears only after work was in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a transaction in work");

    // modulus writes are taken only while idle
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_in_stall)
        else $error("configuration ready while busy");

endmodule

bind modular_arithmetic_unit mau_checker #(.MODULUS_BITS(MODULUS_BITS)) u_mau_checker (.*);
